>>> src/mt64_pkg.sv
// Shared types, constants and functions of the 64-bit Mersenne Twister.
`timescale 1ns / 1ps
`default_nettype none
package mt64_pkg;

  localparam int unsigned STATE_WORDS   = 312;
  localparam int unsigned MIDDLE_OFFSET = 156;
  localparam int unsigned IDX_W         = $clog2(STATE_WORDS);
  localparam int unsigned WORD_W        = 64;

  localparam logic [WORD_W-1:0] SEED_DEFAULT = 64'd5489;
  localparam logic [WORD_W-1:0] SEED_MULT    = 64'd6364136223846793005;
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
  localparam logic [WORD_W-1:0] HIGH_PART    = 64'hFFFF_FFFF_8000_0000;
  localparam logic [WORD_W-1:0] LOW_PART     = 64'h0000_0000_7FFF_FFFF;
  localparam logic [WORD_W-1:0] TEMPER_B     = 64'h5555_5555_5555_5555;
  localparam logic [WORD_W-1:0] TEMPER_C     = 64'h71D6_7FFF_EDA6_0000;
  localparam logic [WORD_W-1:0] TEMPER_D     = 64'hFFF7_EEE0_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED0,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_SEEDWR,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_CALC,
    ST_TWWR,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    MUL_LL,
    MUL_LH,
    MUL_HL
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [1:0] {
    RD_CUR,
    RD_NXT,
    RD_FAR
  } rd_sel_e;

  typedef struct packed {
    logic     seed_start;
    logic     mul_en;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     seed_write;
    rd_sel_e  rd_sel;
    logic     cap_cur;
    logic     cap_nxt;
    logic     twist_calc;
    logic     tw_write;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic seeded;
    logic seed_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x;
    y = y ^ ((y >> 29) & TEMPER_B);
    y = y ^ ((y << 17) & TEMPER_C);
    y = y ^ ((y << 37) & TEMPER_D);
    y = y ^ (y >> 43);
    return y;
  endfunction

endpackage
`default_nettype wire

>>> src/mt64_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mt64_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 312
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> src/mt64_datapath.sv
// Datapath: seed register, seeding multiplier, state table, lazy twist and tempering.
`timescale 1ns / 1ps
`default_nettype none
module mt64_datapath
  import mt64_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [WORD_W-1:0] cfg_wdata_i,
  input  wire ctrl_cmd_t         cmd_i,
  output dp_status_t             status_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic      [WORD_W-1:0] out_data_o
);

  logic [WORD_W-1:0] seed_q;
  logic [WORD_W-1:0] prev_q, prev_d;
  logic [WORD_W-1:0] mul_q, mul_d;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              seeded_q, seeded_d;
  logic [WORD_W-1:0] cur_q, nxt_q, word_q;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_data_q, out_data_d;

  logic [WORD_W-1:0] mix;
  logic [31:0]       mul_a, mul_b;
  logic [IDX_W-1:0]  nxt_idx, far_idx;
  logic [WORD_W-1:0] twist_y, twist_v;
  logic              out_free;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_DEFAULT;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  // Seeding recurrence: the low 64 bits of the product are built from three
  // 32x32 partial products, one per cycle, on the shared multiplier.
  assign mix = prev_q ^ (prev_q >> 62);

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_LL: begin
        mul_a = mix[31:0];
        mul_b = SEED_MULT[31:0];
      end
      MUL_LH: begin
        mul_a = mix[31:0];
        mul_b = SEED_MULT[63:32];
      end
      MUL_HL: begin
        mul_a = mix[63:32];
        mul_b = SEED_MULT[31:0];
      end
      default: begin
        mul_a = mix[31:0];
        mul_b = SEED_MULT[31:0];
      end
    endcase
  end

  assign mul_d = cmd_i.mul_en ? ({32'd0, mul_a} * {32'd0, mul_b}) : mul_q;

  always_comb begin
    case (cmd_i.acc_op)
      ACC_LOAD: acc_d = mul_q + WORD_W'(cnt_q);
      ACC_ADD:  acc_d = acc_q + {mul_q[31:0], 32'd0};
      default:  acc_d = acc_q;
    endcase
  end

  assign nxt_idx = (idx_q == IDX_W'(STATE_WORDS - 1)) ? '0 : idx_q + 1'b1;
  assign far_idx = (idx_q < IDX_W'(MIDDLE_OFFSET)) ? idx_q + IDX_W'(MIDDLE_OFFSET)
                                                   : idx_q - IDX_W'(MIDDLE_OFFSET);

  // Words below the index are already twisted for this pass, the rest are not,
  // so twisting one word on demand reads exactly what the full pass would.
  assign twist_y = (cur_q & HIGH_PART) | (nxt_q & LOW_PART);
  assign twist_v = ram_rdata ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : '0);

  always_comb begin
    prev_d   = prev_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    seeded_d = seeded_q;
    if (cmd_i.seed_start) begin
      prev_d = seed_q;
      cnt_d  = IDX_W'(1);
    end
    if (cmd_i.seed_write) begin
      prev_d = acc_q;
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == IDX_W'(STATE_WORDS - 1)) begin
        idx_d    = '0;
        seeded_d = 1'b1;
      end
    end
    if (cmd_i.tw_write) begin
      idx_d = nxt_idx;
    end
  end

  always_comb begin
    ram_we    = cmd_i.seed_start | cmd_i.seed_write | cmd_i.tw_write;
    ram_waddr = idx_q;
    ram_wdata = word_q;
    if (cmd_i.seed_start) begin
      ram_waddr = '0;
      ram_wdata = seed_q;
    end else if (cmd_i.seed_write) begin
      ram_waddr = cnt_q;
      ram_wdata = acc_q;
    end
    case (cmd_i.rd_sel)
      RD_CUR:  ram_raddr = idx_q;
      RD_NXT:  ram_raddr = nxt_idx;
      RD_FAR:  ram_raddr = far_idx;
      default: ram_raddr = idx_q;
    endcase
  end

  mt64_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STATE_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = temper(word_q);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      cnt_q       <= '0;
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q     <= prev_d;
    mul_q      <= mul_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
    if (cmd_i.cap_cur) begin
      cur_q <= ram_rdata;
    end
    if (cmd_i.cap_nxt) begin
      nxt_q <= ram_rdata;
    end
    if (cmd_i.twist_calc) begin
      word_q <= twist_v;
    end
  end

  assign status_o.seeded    = seeded_q;
  assign status_o.seed_last = (cnt_q == IDX_W'(STATE_WORDS - 1));
  assign status_o.out_free  = out_free;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_data_q;

endmodule
`default_nettype wire

>>> src/mt64_ctrl.sv
// Controller state machine: sequences seeding, on-demand twist and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module mt64_ctrl
  import mt64_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_restart_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_restart_i || !status_i.seeded) ? ST_SEED0 : ST_RD0;
        end
      end
      ST_SEED0:  state_d = ST_MUL0;
      ST_MUL0:   state_d = ST_MUL1;
      ST_MUL1:   state_d = ST_MUL2;
      ST_MUL2:   state_d = ST_MUL3;
      ST_MUL3:   state_d = ST_SEEDWR;
      ST_SEEDWR: state_d = status_i.seed_last ? ST_RD0 : ST_MUL0;
      ST_RD0:    state_d = ST_RD1;
      ST_RD1:    state_d = ST_RD2;
      ST_RD2:    state_d = ST_CALC;
      ST_CALC:   state_d = ST_TWWR;
      ST_TWWR:   state_d = ST_OUT;
      ST_OUT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_LL;
    cmd_o.acc_op  = ACC_HOLD;
    cmd_o.rd_sel  = RD_CUR;
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_SEED0: cmd_o.seed_start = 1'b1;
      ST_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LL;
      end
      ST_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_LH;
        cmd_o.acc_op  = ACC_LOAD;
      end
      ST_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_HL;
        cmd_o.acc_op  = ACC_ADD;
      end
      ST_MUL3:   cmd_o.acc_op = ACC_ADD;
      ST_SEEDWR: cmd_o.seed_write = 1'b1;
      ST_RD0:    cmd_o.rd_sel = RD_CUR;
      ST_RD1: begin
        cmd_o.rd_sel  = RD_NXT;
        cmd_o.cap_cur = 1'b1;
      end
      ST_RD2: begin
        cmd_o.rd_sel  = RD_FAR;
        cmd_o.cap_nxt = 1'b1;
      end
      ST_CALC:  cmd_o.twist_calc = 1'b1;
      ST_TWWR:  cmd_o.tw_write = 1'b1;
      ST_OUT:   cmd_o.out_load = status_i.out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/mersenne_twister_64.sv
// The result is offered after the three table reads, the twist and the write-back of its word, when seeded.
// A seeding item (first after reset, or restart set) first writes the seed, then the 311 further table words;
// each seed word takes three passes through the shared 32x32 multiplier.
// The block takes a new item only once the result of the last one is loaded into the output register.
// Reset clears the controller and output valid, loads seed 5489 and marks the
// table unseeded; the table memory itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module mersenne_twister_64
  import mt64_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [63:0] m_axis_tdata    // [63:0] random_word
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mt64_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_restart_i(s_axis_tdata[0]),
    .in_ready_o  (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mt64_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (m_axis_tdata)
  );

endmodule
`default_nettype wire

>>> src/mt64_checker.sv
// Port-level checks for the 64-bit Mersenne Twister, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mt64_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata
);

  // A pending result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped before it was taken");

  // The offered word does not change while it waits.
  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result item changed before it was taken");

  // One item at a time: the input closes right after an item is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input open in the cycle after an accepted item");

  // A new result appears only once its item is finished, so the input reopens with it.
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result presented while the item is still in work");

endmodule

bind mersenne_twister_64 mt64_checker u_mt64_checker (.*);
`default_nettype wire
